// ===== hw/rtl/ifla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifla_pkg
// Shared codes and field widths of the indexed free list allocator.
// ----------------------------------------------------------------------------
package ifla_pkg;

    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 11;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic IDX_ITEM_COUNT = 1'b0;
    localparam logic [COUNT_W-1:0] ITEM_COUNT_RST = 11'd1024;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_FREE   = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_FORMAT = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_RANGE    = 3'd2,
        ST_NOT_USED = 3'd3,
        ST_NOT_FMT  = 3'd4
    } t_status;

endpackage

// ===== hw/rtl/indexed_free_list_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_free_list_allocator_top
// Slot allocator keeping a free list and a used list, both doubly linked,
// over one entry memory of MAX_ITEMS words {used, next, prev}.
//
//   channel   signals                                  direction
//   command   start, busy, i_func, i_slot              in  (busy back)
//   result    o_valid, o_status, o_result_slot,        out (no stall)
//             o_in_use, o_next_valid, o_next_slot,
//             o_used_total
//   config    psel, penable, pwrite, paddr, pwdata,    in  (APB)
//             prdata, pready
//
// Range, full and unformatted errors are answered from S_IDLE; a query or
// a not-in-use error from S_LINK after the entry read. Allocate goes on to
// S_W2 and S_W3, free to S_W2 to S_W4; format writes one entry per cycle in
// S_FMT. The single write port of the entry memory sets these steps.
// Synchronous active-low reset; the entry memory is not cleared and holds
// nothing valid until the first format. The result is a one-cycle strobe.
// ----------------------------------------------------------------------------
module indexed_free_list_allocator_top #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ifla_pkg::FUNC_W-1:0]     i_func,
    input  logic [ifla_pkg::SLOT_W-1:0]     i_slot,
    output logic                            o_valid,
    output logic [ifla_pkg::STATUS_W-1:0]   o_status,
    output logic [ifla_pkg::SLOT_W-1:0]     o_result_slot,
    output logic                            o_in_use,
    output logic                            o_next_valid,
    output logic [ifla_pkg::SLOT_W-1:0]     o_next_slot,
    output logic [ifla_pkg::COUNT_W-1:0]    o_used_total,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ifla_pkg::APB_AW-1:0]     paddr,
    input  logic [ifla_pkg::APB_DW-1:0]     pwdata,
    output logic [ifla_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef struct packed {
        logic          none;
        logic [IW-1:0] idx;
    } t_link;

    typedef struct packed {
        logic  used;
        t_link nxt;
        t_link prv;
    } t_entry;

    typedef struct packed {
        logic used;
        logic nxt;
        logic prv;
    } t_wmask;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LINK,
        S_W2,
        S_W3,
        S_W4,
        S_FMT
    } t_state;

    localparam t_link LINK_NONE = '{none: 1'b1, idx: '0};

    t_entry r_mem [MAX_ITEMS];
    t_entry r_rd;

    t_state            r_state, n_state;
    ifla_pkg::t_func   r_func, n_func;
    logic [ifla_pkg::SLOT_W-1:0] r_slot, n_slot;
    t_link             r_free_head, n_free_head;
    t_link             r_used_head, n_used_head;
    t_link             r_nx, n_nx;
    t_link             r_pv, n_pv;
    logic [CW-1:0]     r_used_count, n_used_count;
    logic              r_formatted, n_formatted;
    logic [IW-1:0]     r_idx, n_idx;
    logic [ifla_pkg::COUNT_W-1:0] r_item_count;
    logic              r_valid, n_valid;
    ifla_pkg::t_status r_status, n_status;
    logic [ifla_pkg::SLOT_W-1:0] r_rslot, n_rslot;
    logic              r_in_use, n_in_use;
    logic              r_nvalid, n_nvalid;
    logic [ifla_pkg::SLOT_W-1:0] r_nslot, n_nslot;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    t_wmask        w_en;
    logic [IW-1:0] w_addr;
    t_entry        w_data;

    logic [CW-1:0] count;
    logic          slot_ok;
    logic          full;
    logic [IW-1:0] slot_idx;
    logic [CW-1:0] idx_inc;
    logic          cfg_wr;

    // effective count, saturated to 1..MAX_ITEMS
    always_comb begin
        if (r_item_count == '0) begin
            count = CW'(1);
        end else if (32'(r_item_count) > 32'(MAX_ITEMS)) begin
            count = CW'(MAX_ITEMS);
        end else begin
            count = CW'(r_item_count);
        end
    end

    assign slot_ok  = 32'(i_slot) < 32'(count);
    assign full     = (r_used_count >= count) || r_free_head.none ||
                      (32'(r_free_head.idx) >= 32'(count));
    assign slot_idx = IW'(r_slot);
    assign idx_inc  = CW'(r_idx) + CW'(1);

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_slot       = r_slot;
        n_free_head  = r_free_head;
        n_used_head  = r_used_head;
        n_nx         = r_nx;
        n_pv         = r_pv;
        n_used_count = r_used_count;
        n_formatted  = r_formatted;
        n_idx        = r_idx;
        n_valid      = 1'b0;
        n_status     = r_status;
        n_rslot      = r_rslot;
        n_in_use     = r_in_use;
        n_nvalid     = r_nvalid;
        n_nslot      = r_nslot;
        rd_en        = 1'b0;
        rd_addr      = '0;
        w_en         = '0;
        w_addr       = '0;
        w_data       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func   = ifla_pkg::t_func'(i_func);
                    n_slot   = i_slot;
                    n_status = ifla_pkg::ST_OK;
                    n_rslot  = '0;
                    n_in_use = 1'b0;
                    n_nvalid = 1'b0;
                    n_nslot  = '0;
                    if (ifla_pkg::t_func'(i_func) == ifla_pkg::FUNC_FORMAT) begin
                        n_idx   = '0;
                        n_state = S_FMT;
                    end else if (!r_formatted) begin
                        n_status = ifla_pkg::ST_NOT_FMT;
                        n_valid  = 1'b1;
                    end else if (ifla_pkg::t_func'(i_func) == ifla_pkg::FUNC_ALLOC) begin
                        if (full) begin
                            n_status = ifla_pkg::ST_FULL;
                            n_valid  = 1'b1;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_free_head.idx;
                            n_state = S_LINK;
                        end
                    end else begin
                        n_rslot = i_slot;
                        if (!slot_ok) begin
                            n_status = ifla_pkg::ST_RANGE;
                            n_valid  = 1'b1;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = IW'(i_slot);
                            n_state = S_LINK;
                        end
                    end
                end
            end
            S_LINK: begin
                case (r_func)
                    ifla_pkg::FUNC_ALLOC: begin
                        n_nx       = r_rd.nxt;
                        w_en.prv   = !r_rd.nxt.none;
                        w_addr     = r_rd.nxt.idx;
                        w_data.prv = LINK_NONE;
                        n_state    = S_W2;
                    end
                    ifla_pkg::FUNC_FREE: begin
                        if (!r_rd.used) begin
                            n_status = ifla_pkg::ST_NOT_USED;
                            n_valid  = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_nx = r_rd.nxt;
                            n_pv = r_rd.prv;
                            if (!r_used_head.none && (r_used_head.idx == slot_idx)) begin
                                n_used_head = r_rd.nxt;
                            end
                            w_en.prv   = !r_rd.nxt.none;
                            w_addr     = r_rd.nxt.idx;
                            w_data.prv = r_rd.prv;
                            n_state    = S_W2;
                        end
                    end
                    default: begin
                        if (!r_rd.used) begin
                            n_status = ifla_pkg::ST_NOT_USED;
                        end else begin
                            n_in_use = 1'b1;
                            if (!r_rd.nxt.none) begin
                                n_nvalid = 1'b1;
                                n_nslot  = ifla_pkg::SLOT_W'(r_rd.nxt.idx);
                            end
                        end
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_W2: begin
                if (r_func == ifla_pkg::FUNC_ALLOC) begin
                    w_en   = '{used: 1'b1, nxt: 1'b1, prv: 1'b1};
                    w_addr = r_free_head.idx;
                    w_data = '{used: 1'b1, nxt: r_used_head, prv: LINK_NONE};
                end else begin
                    w_en.nxt   = !r_pv.none;
                    w_addr     = r_pv.idx;
                    w_data.nxt = r_nx;
                end
                n_state = S_W3;
            end
            S_W3: begin
                if (r_func == ifla_pkg::FUNC_ALLOC) begin
                    w_en.prv     = !r_used_head.none;
                    w_addr       = r_used_head.idx;
                    w_data.prv   = '{none: 1'b0, idx: r_free_head.idx};
                    n_free_head  = r_nx;
                    n_used_head  = '{none: 1'b0, idx: r_free_head.idx};
                    n_used_count = r_used_count + CW'(1);
                    n_rslot      = ifla_pkg::SLOT_W'(r_free_head.idx);
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    w_en    = '{used: 1'b1, nxt: 1'b1, prv: 1'b1};
                    w_addr  = slot_idx;
                    w_data  = '{used: 1'b0, nxt: r_free_head, prv: LINK_NONE};
                    n_state = S_W4;
                end
            end
            S_W4: begin
                w_en.prv    = !r_free_head.none;
                w_addr      = r_free_head.idx;
                w_data.prv  = '{none: 1'b0, idx: slot_idx};
                n_free_head = '{none: 1'b0, idx: slot_idx};
                if (r_used_count != '0) begin
                    n_used_count = r_used_count - CW'(1);
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_FMT: begin
                w_en        = '{used: 1'b1, nxt: 1'b1, prv: 1'b1};
                w_addr      = r_idx;
                w_data.used = 1'b0;
                w_data.nxt  = LINK_NONE;
                w_data.prv  = LINK_NONE;
                if (r_idx != '0) begin
                    w_data.prv = '{none: 1'b0, idx: r_idx - IW'(1)};
                end
                if (idx_inc < count) begin
                    w_data.nxt = '{none: 1'b0, idx: IW'(idx_inc)};
                    n_idx      = IW'(idx_inc);
                end else begin
                    n_free_head  = '{none: 1'b0, idx: '0};
                    n_used_head  = LINK_NONE;
                    n_used_count = '0;
                    n_formatted  = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_func       <= ifla_pkg::FUNC_ALLOC;
            r_slot       <= '0;
            r_free_head  <= LINK_NONE;
            r_used_head  <= LINK_NONE;
            r_nx         <= LINK_NONE;
            r_pv         <= LINK_NONE;
            r_used_count <= '0;
            r_formatted  <= 1'b0;
            r_idx        <= '0;
            r_valid      <= 1'b0;
            r_status     <= ifla_pkg::ST_OK;
            r_rslot      <= '0;
            r_in_use     <= 1'b0;
            r_nvalid     <= 1'b0;
            r_nslot      <= '0;
        end else begin
            r_state      <= n_state;
            r_func       <= n_func;
            r_slot       <= n_slot;
            r_free_head  <= n_free_head;
            r_used_head  <= n_used_head;
            r_nx         <= n_nx;
            r_pv         <= n_pv;
            r_used_count <= n_used_count;
            r_formatted  <= n_formatted;
            r_idx        <= n_idx;
            r_valid      <= n_valid;
            r_status     <= n_status;
            r_rslot      <= n_rslot;
            r_in_use     <= n_in_use;
            r_nvalid     <= n_nvalid;
            r_nslot      <= n_nslot;
        end
    end

    // entry memory: one write port with field mask, one registered read
    always_ff @(posedge i_clk) begin
        if (w_en.used) begin
            r_mem[w_addr].used <= w_data.used;
        end
        if (w_en.nxt) begin
            r_mem[w_addr].nxt <= w_data.nxt;
        end
        if (w_en.prv) begin
            r_mem[w_addr].prv <= w_data.prv;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= ifla_pkg::ITEM_COUNT_RST;
        end else if (cfg_wr && (paddr[2] == ifla_pkg::IDX_ITEM_COUNT)) begin
            r_item_count <= pwdata[ifla_pkg::COUNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ifla_pkg::IDX_ITEM_COUNT) ?
                    ifla_pkg::APB_DW'(r_item_count) : '0;

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_result_slot = r_rslot;
    assign o_in_use      = r_in_use;
    assign o_next_valid  = r_nvalid;
    assign o_next_slot   = r_nslot;
    assign o_used_total  = ifla_pkg::COUNT_W'(r_used_count);

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("accepted word produced neither result nor work");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used_count) <= 32'(MAX_ITEMS))
        else $error("used count above capacity");

    a_unformatted_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_formatted |-> (r_used_count == '0))
        else $error("used entries before format");

    a_alloc_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_func == ifla_pkg::FUNC_ALLOC) && (r_status == ifla_pkg::ST_OK))
        |-> (!r_used_head.none && (r_used_count != '0)))
        else $error("allocate left used list empty");

endmodule

// ===== sim/tb_indexed_free_list_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_free_list_allocator_top
// Self-checking bench for the slot allocator. Command words go in through the
// start/busy handshake. A local mirror of the entry table, both lists and the
// item_count register computes each expected outcome. Result strobes are
// compared field by field in order. Directed words cover the unformatted
// block, list edges and count saturation. Randomized phases follow, with
// varied item_count settings and sender gaps.
// ----------------------------------------------------------------------------
module tb_indexed_free_list_allocator_top;

    localparam int MAX_ITEMS     = 1024;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int MAX_LOGGED    = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [ifla_pkg::COUNT_W-1:0] LINK_NONE = '1;

    typedef struct packed {
        ifla_pkg::t_status                 status;
        logic [ifla_pkg::SLOT_W-1:0]       slot;
        logic                              in_use;
        logic                              next_valid;
        logic [ifla_pkg::SLOT_W-1:0]       next_slot;
        logic [ifla_pkg::COUNT_W-1:0]      used_total;
    } t_alloc_result;

    logic                              i_clk   = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start   = 1'b0;
    logic                              busy;
    logic [ifla_pkg::FUNC_W-1:0]       i_func  = '0;
    logic [ifla_pkg::SLOT_W-1:0]       i_slot  = '0;
    logic                              o_valid;
    logic [ifla_pkg::STATUS_W-1:0]     o_status;
    logic [ifla_pkg::SLOT_W-1:0]       o_result_slot;
    logic                              o_in_use;
    logic                              o_next_valid;
    logic [ifla_pkg::SLOT_W-1:0]       o_next_slot;
    logic [ifla_pkg::COUNT_W-1:0]      o_used_total;
    logic                              psel    = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite  = 1'b0;
    logic [ifla_pkg::APB_AW-1:0]       paddr   = '0;
    logic [ifla_pkg::APB_DW-1:0]       pwdata  = '0;
    logic [ifla_pkg::APB_DW-1:0]       prdata;
    logic                              pready;

    // mirror of the allocator
    logic                              mark_m [MAX_ITEMS];
    logic [ifla_pkg::COUNT_W-1:0]      next_m [MAX_ITEMS];
    logic [ifla_pkg::COUNT_W-1:0]      prev_m [MAX_ITEMS];
    logic [ifla_pkg::COUNT_W-1:0]      free_head_m  = LINK_NONE;
    logic [ifla_pkg::COUNT_W-1:0]      used_head_m  = LINK_NONE;
    logic [ifla_pkg::COUNT_W-1:0]      item_count_m = ifla_pkg::ITEM_COUNT_RST;
    int                                used_count_m = 0;
    bit                                formatted_m  = 1'b0;
    int                                written_top  = 0;

    t_alloc_result        outcome_q[$];

    int idle_pct     = 0;
    int big_left     = 3;
    int words_sent   = 0;
    int checked      = 0;
    int errors       = 0;
    int count_writes = 0;
    int format_count = 0;
    int cycle_count  = 0;
    int status_seen [5];

    indexed_free_list_allocator_top #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_slot        (i_slot),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_result_slot (o_result_slot),
        .o_in_use      (o_in_use),
        .o_next_valid  (o_next_valid),
        .o_next_slot   (o_next_slot),
        .o_used_total  (o_used_total),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic int active_count();
        if (item_count_m == 0) return 1;
        if (item_count_m > MAX_ITEMS) return MAX_ITEMS;
        return int'(item_count_m);
    endfunction

    function automatic bit link_valid(input logic [ifla_pkg::COUNT_W-1:0] v);
        return v < MAX_ITEMS;
    endfunction

    task automatic apply_command(input ifla_pkg::t_func f,
                                 input logic [ifla_pkg::SLOT_W-1:0] s);
        t_alloc_result                 r;
        int                            cnt;
        logic [ifla_pkg::COUNT_W-1:0]  e;
        logic [ifla_pkg::COUNT_W-1:0]  nx;
        logic [ifla_pkg::COUNT_W-1:0]  pv;
        logic [ifla_pkg::COUNT_W-1:0]  sx;
        r        = '0;
        r.status = ifla_pkg::ST_OK;
        cnt      = active_count();
        sx       = {1'b0, s};
        if (f == ifla_pkg::FUNC_FORMAT) begin
            for (int i = 0; i < cnt; i++) begin
                mark_m[i] = 1'b0;
                prev_m[i] = (i == 0) ? LINK_NONE : ifla_pkg::COUNT_W'(i - 1);
                next_m[i] = (i + 1 < cnt) ? ifla_pkg::COUNT_W'(i + 1) : LINK_NONE;
            end
            free_head_m  = '0;
            used_head_m  = LINK_NONE;
            used_count_m = 0;
            formatted_m  = 1'b1;
            if (cnt > written_top) written_top = cnt;
            format_count++;
        end else if (!formatted_m) begin
            r.status = ifla_pkg::ST_NOT_FMT;
        end else if (f == ifla_pkg::FUNC_ALLOC) begin
            if (used_count_m >= cnt || free_head_m == LINK_NONE || free_head_m >= cnt) begin
                r.status = ifla_pkg::ST_FULL;
            end else begin
                e           = free_head_m;
                free_head_m = next_m[e];
                if (link_valid(free_head_m)) prev_m[free_head_m] = LINK_NONE;
                mark_m[e] = 1'b1;
                next_m[e] = used_head_m;
                prev_m[e] = LINK_NONE;
                if (link_valid(used_head_m)) prev_m[used_head_m] = e;
                used_head_m = e;
                used_count_m++;
                r.slot = e[ifla_pkg::SLOT_W-1:0];
            end
        end else if (f == ifla_pkg::FUNC_FREE) begin
            r.slot = s;
            if (s >= cnt) begin
                r.status = ifla_pkg::ST_RANGE;
            end else if (!mark_m[s]) begin
                r.status = ifla_pkg::ST_NOT_USED;
            end else begin
                nx = next_m[s];
                pv = prev_m[s];
                if (sx == used_head_m) used_head_m = nx;
                if (link_valid(nx)) prev_m[nx] = pv;
                if (link_valid(pv)) next_m[pv] = nx;
                mark_m[s] = 1'b0;
                prev_m[s] = LINK_NONE;
                next_m[s] = free_head_m;
                if (link_valid(free_head_m)) prev_m[free_head_m] = sx;
                free_head_m = sx;
                if (used_count_m > 0) used_count_m--;
            end
        end else begin
            r.slot = s;
            if (s >= cnt) begin
                r.status = ifla_pkg::ST_RANGE;
            end else if (!mark_m[s]) begin
                r.status = ifla_pkg::ST_NOT_USED;
            end else begin
                r.in_use = 1'b1;
                nx = next_m[s];
                if (link_valid(nx)) begin
                    r.next_valid = 1'b1;
                    r.next_slot  = nx[ifla_pkg::SLOT_W-1:0];
                end
            end
        end
        r.used_total = ifla_pkg::COUNT_W'(used_count_m);
        status_seen[int'(r.status)]++;
        outcome_q.push_back(r);
    endtask

    // random member of the used list
    function automatic logic [ifla_pkg::SLOT_W-1:0] pick_used_slot();
        logic [ifla_pkg::COUNT_W-1:0] p;
        int                           steps;
        if (used_count_m == 0 || !link_valid(used_head_m))
            return ifla_pkg::SLOT_W'($urandom);
        steps = $urandom_range(used_count_m - 1, 0);
        p     = used_head_m;
        repeat (steps) if (link_valid(next_m[p])) p = next_m[p];
        return p[ifla_pkg::SLOT_W-1:0];
    endfunction

    // keep free/query off entries that no format has written
    function automatic logic [ifla_pkg::SLOT_W-1:0] written_slot(
        input logic [ifla_pkg::SLOT_W-1:0] s);
        if (formatted_m && s < active_count() && s >= written_top)
            return ifla_pkg::SLOT_W'($urandom_range(written_top - 1, 0));
        return s;
    endfunction

    task automatic send_word(input ifla_pkg::t_func f,
                             input logic [ifla_pkg::SLOT_W-1:0] s);
        logic [ifla_pkg::SLOT_W-1:0] sl;
        sl = (f == ifla_pkg::FUNC_FREE || f == ifla_pkg::FUNC_QUERY) ? written_slot(s) : s;
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_func <= f;
        i_slot <= sl;
        do @(posedge i_clk); while (busy);
        apply_command(f, sl);
        words_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (outcome_q.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_item_count(input int value);
        logic [ifla_pkg::APB_DW-1:0] wr;
        wait_drained();
        wr = $urandom;
        if ($urandom_range(3, 0) != 0) wr[ifla_pkg::APB_DW-1:ifla_pkg::COUNT_W] = '0;
        wr[ifla_pkg::COUNT_W-1:0] = ifla_pkg::COUNT_W'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ifla_pkg::APB_AW'(4 * int'(ifla_pkg::IDX_ITEM_COUNT));
        pwdata  <= wr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        item_count_m = wr[ifla_pkg::COUNT_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        count_writes++;
    endtask

    task automatic test_unformatted();
        send_word(ifla_pkg::FUNC_ALLOC, '0);
        send_word(ifla_pkg::FUNC_FREE, '1);
        send_word(ifla_pkg::FUNC_QUERY, ifla_pkg::SLOT_W'($urandom));
    endtask

    task automatic test_list_edges();
        write_item_count(4);
        send_word(ifla_pkg::FUNC_FORMAT, '0);
        repeat (5) send_word(ifla_pkg::FUNC_ALLOC, ifla_pkg::SLOT_W'($urandom));
        send_word(ifla_pkg::FUNC_QUERY, 10'd2);
        send_word(ifla_pkg::FUNC_QUERY, 10'd0);
        send_word(ifla_pkg::FUNC_FREE, 10'd2);
        send_word(ifla_pkg::FUNC_FREE, 10'd3);
        send_word(ifla_pkg::FUNC_FREE, 10'd0);
        send_word(ifla_pkg::FUNC_FREE, 10'd0);
        send_word(ifla_pkg::FUNC_QUERY, '1);
        send_word(ifla_pkg::FUNC_ALLOC, '1);
    endtask

    task automatic test_count_limits();
        write_item_count(0);
        send_word(ifla_pkg::FUNC_FORMAT, '1);
        send_word(ifla_pkg::FUNC_ALLOC, '0);
        send_word(ifla_pkg::FUNC_ALLOC, '0);
        send_word(ifla_pkg::FUNC_QUERY, 10'd1);
        write_item_count(2047);
        send_word(ifla_pkg::FUNC_FORMAT, '0);
        send_word(ifla_pkg::FUNC_ALLOC, '0);
        send_word(ifla_pkg::FUNC_QUERY, '1);
        // count moved after format
        write_item_count(8);
        send_word(ifla_pkg::FUNC_FORMAT, '0);
        send_word(ifla_pkg::FUNC_ALLOC, '0);
        send_word(ifla_pkg::FUNC_ALLOC, '0);
        write_item_count(1);
        send_word(ifla_pkg::FUNC_ALLOC, '0);
        send_word(ifla_pkg::FUNC_QUERY, 10'd1);
        write_item_count(16);
        send_word(ifla_pkg::FUNC_QUERY, 10'd12);
        send_word(ifla_pkg::FUNC_ALLOC, '0);
    endtask

    task automatic test_random_phase(input int n_words);
        int roll;
        int alloc_w;
        int cnt_val;
        roll = $urandom_range(99, 0);
        if (roll < 8) begin
            cnt_val = 0;
        end else if (roll < 16) begin
            cnt_val = 1;
        end else if (roll < 24) begin
            cnt_val = 2;
        end else if (roll < 34 && big_left > 0) begin
            cnt_val = (roll < 29) ? 2047 : 1024;
            big_left--;
        end else begin
            cnt_val = $urandom_range(48, 3);
        end
        write_item_count(cnt_val);
        send_word(ifla_pkg::FUNC_FORMAT, ifla_pkg::SLOT_W'($urandom));
        alloc_w = $urandom_range(50, 25);
        repeat (n_words) begin
            roll = $urandom_range(99, 0);
            if (roll < alloc_w)
                send_word(ifla_pkg::FUNC_ALLOC, ifla_pkg::SLOT_W'($urandom));
            else if (roll < alloc_w + 25)
                send_word(ifla_pkg::FUNC_FREE, pick_used_slot());
            else if (roll < alloc_w + 35)
                send_word(ifla_pkg::FUNC_QUERY, pick_used_slot());
            else if (roll < alloc_w + 41)
                send_word(ifla_pkg::FUNC_QUERY, ifla_pkg::SLOT_W'($urandom));
            else if (roll < alloc_w + 46)
                send_word(ifla_pkg::FUNC_FREE, ifla_pkg::SLOT_W'($urandom));
            else if (roll < alloc_w + 48 && active_count() <= 64)
                send_word(ifla_pkg::FUNC_FORMAT, ifla_pkg::SLOT_W'($urandom));
            else if (roll < alloc_w + 50)
                write_item_count($urandom_range(64, 1));
            else if (roll < alloc_w + 51)
                wait_drained();
            else
                send_word(ifla_pkg::FUNC_ALLOC, ifla_pkg::SLOT_W'($urandom));
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_alloc_result want;
        if (i_rst_n && o_valid) begin
            if (outcome_q.size() == 0) begin
                errors++;
                if (errors <= MAX_LOGGED)
                    $display("Unexpected result word: status %0d slot %0d total %0d",
                             o_status, o_result_slot, o_used_total);
            end else begin
                want = outcome_q.pop_front();
                checked++;
                if (o_status !== want.status || o_result_slot !== want.slot ||
                    o_in_use !== want.in_use || o_next_valid !== want.next_valid ||
                    o_next_slot !== want.next_slot || o_used_total !== want.used_total) begin
                    errors++;
                    if (errors <= MAX_LOGGED) begin
                        $display("Mismatch on result %0d: expected st=%0d slot=%0d use=%0d nv=%0d nx=%0d tot=%0d",
                                 checked, want.status, want.slot, want.in_use,
                                 want.next_valid, want.next_slot, want.used_total);
                        $display("    got st=%0d slot=%0d use=%0d nv=%0d nx=%0d tot=%0d",
                                 o_status, o_result_slot, o_in_use, o_next_valid,
                                 o_next_slot, o_used_total);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, outcome_q.size());
        $display("indexed_free_list_allocator_top verification failed");
        $finish;
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_pct = 25;
        test_unformatted();
        test_list_edges();
        test_count_limits();
        for (int mode = 0; mode < 3; mode++) begin
            idle_pct = (mode == 0) ? 25 : (mode == 1) ? 45 : 0;
            repeat (6) test_random_phase(82);
        end
        wait_drained();
        if (outcome_q.size() != 0) begin
            errors++;
            $display("%0d expected results never arrived", outcome_q.size());
        end
        $display("Covered %0d command words, %0d item_count writes, %0d formats; %0d checked",
                 words_sent, count_writes, format_count, checked);
        $display("Outcomes: ok %0d, full %0d, out of range %0d, not in use %0d, unformatted %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (errors == 0) begin
            $display("indexed_free_list_allocator_top verification clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("indexed_free_list_allocator_top verification failed");
        end
        $finish;
    end

endmodule
